// ===== rtl/grid_astar_path_search_top_macros.svh =====
// assertion macros for the grid path search block
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define GAPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gaps assertion failed");

// next-cycle implication, held off during reset
`define GAPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gaps assertion failed");

// next-cycle implication that also covers reset
`define GAPS_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gaps assertion failed");

`endif

// ===== rtl/gaps_pkg.sv =====
// types, constants and helpers shared by the grid path search block
`default_nettype none
package gaps_pkg;

  localparam int GRID_ROWS      = 16;
  localparam int GRID_COLS      = 16;
  localparam int FRONTIER_DEPTH = 1024;
  localparam int NCELLS         = GRID_ROWS * GRID_COLS;

  localparam int CELL_W  = 8;
  localparam int COST_W  = 25;
  localparam int LEN_W   = 9;
  localparam int PRIO_W  = COST_W + 1;
  localparam int SEQ_W   = 32;
  localparam int ROW_W   = $clog2(GRID_ROWS);
  localparam int COL_W   = $clog2(GRID_COLS);
  localparam int DIST_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int FIDX_W  = $clog2(FRONTIER_DEPTH);
  localparam int FCNT_W  = FIDX_W + 1;
  localparam int PROD_W  = 17;

  localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};
  localparam logic [8:0] ORTHO_WEIGHT = 9'd256;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FOUND    = 2'd1,
    ST_NO_PATH  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [FIDX_W-1:0] fidx_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  cell_index;
    logic [7:0]  cell_cost;
    logic [7:0]  start_cell;
    logic [7:0]  finish_cell;
    logic [7:0]  path_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [COST_W-1:0] total_cost;
    logic [LEN_W-1:0]  path_len;
    logic [7:0]        path_cell;
  } out_item_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [SEQ_W-1:0]  seq;
    cell_t             loc;
  } fentry_t;

  // control from the sequencer to the frontier store
  typedef struct packed {
    logic    rd_en;
    fidx_t   raddr;
    logic    cmp_en;
    logic    cmp_first;
    logic    wr_en;
    fidx_t   waddr;
    fentry_t wdata;
  } fr_cmd_t;

  // neighbor k of 0..8, row offset code 0,1,2 for -1,0,+1
  function automatic logic [1:0] nb_row_code(input logic [3:0] k);
    logic [1:0] v;
    case (k)
      4'd0, 4'd1, 4'd2: v = 2'd0;
      4'd3, 4'd4, 4'd5: v = 2'd1;
      default:          v = 2'd2;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] nb_col_code(input logic [3:0] k);
    logic [1:0] v;
    case (k)
      4'd0, 4'd3, 4'd6: v = 2'd0;
      4'd1, 4'd4, 4'd7: v = 2'd1;
      default:          v = 2'd2;
    endcase
    return v;
  endfunction

  function automatic cell_t cell_of(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    return CELL_W'(r * GRID_COLS + c);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gaps_mul.sv =====
// shared registered multiplier for step cost and heuristic
`default_nettype none
module gaps_mul (
  input  logic                       clk,
  input  logic [7:0]                 a,
  input  logic [8:0]                 b,
  output logic [gaps_pkg::PROD_W-1:0] p
);
  import gaps_pkg::*;

  always_ff @(posedge clk) begin
    p <= {{(PROD_W-8){1'b0}}, a} * {{(PROD_W-9){1'b0}}, b};
  end

endmodule
`default_nettype wire

// ===== rtl/gaps_frontier.sv =====
// frontier store with running minimum search over priority and push order
`default_nettype none
module gaps_frontier (
  input  logic              clk,
  input  gaps_pkg::fr_cmd_t cmd,
  output gaps_pkg::fentry_t rdata,
  output gaps_pkg::fentry_t best,
  output gaps_pkg::fidx_t   best_idx
);
  import gaps_pkg::*;

  fentry_t mem [FRONTIER_DEPTH];
  fidx_t   ridx;
  logic    take;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[cmd.raddr];
      ridx  <= cmd.raddr;
    end
  end

  // lower priority wins, equal priority goes to the older push
  assign take = cmd.cmp_en && (cmd.cmp_first || (rdata.prio < best.prio) ||
                ((rdata.prio == best.prio) && (rdata.seq < best.seq)));

  always_ff @(posedge clk) begin
    if (take) begin
      best     <= rdata;
      best_idx <= ridx;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gaps_core.sv =====
// search sequencer with grid, cost, parent and path stores
`default_nettype none
module gaps_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gaps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gaps_pkg::out_item_t out_data,
  input  logic [7:0]          impassable_cost,
  input  logic [8:0]          diag_weight
);
  import gaps_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE  = 23'b1 << 0,
    S_RDW   = 23'b1 << 1,
    S_INIT  = 23'b1 << 2,
    S_POP   = 23'b1 << 3,
    S_SCAN  = 23'b1 << 4,
    S_SCEND = 23'b1 << 5,
    S_MVRD  = 23'b1 << 6,
    S_MVWR  = 23'b1 << 7,
    S_BC    = 23'b1 << 8,
    S_NB    = 23'b1 << 9,
    S_G1    = 23'b1 << 10,
    S_S1    = 23'b1 << 11,
    S_S2    = 23'b1 << 12,
    S_MUL   = 23'b1 << 13,
    S_MUL2  = 23'b1 << 14,
    S_PUSH  = 23'b1 << 15,
    S_TRBF  = 23'b1 << 16,
    S_TRBFL = 23'b1 << 17,
    S_TRCHK = 23'b1 << 18,
    S_TRDAT = 23'b1 << 19,
    S_FILL  = 23'b1 << 20,
    S_FILLD = 23'b1 << 21,
    S_DONE  = 23'b1 << 22
  } state_t;

  state_t state;

  // stores
  cell_t             grid_mem [NCELLS];
  logic [COST_W-1:0] best_mem [NCELLS];
  cell_t             par_mem  [NCELLS];
  cell_t             path_mem [NCELLS];
  logic [NCELLS-1:0] known;

  cell_t             grid_raddr, best_raddr, best_waddr, par_raddr, path_raddr, path_waddr;
  logic              grid_we, best_we, par_we, path_we;
  logic [COST_W-1:0] best_wdata;
  cell_t             grid_rdata, par_rdata, path_rdata;
  logic [COST_W-1:0] best_rdata;

  // search registers
  cell_t             s_cell, f_cell, cur, tcur;
  logic [FCNT_W-1:0] count;
  logic [SEQ_W-1:0]  seq;
  fidx_t             scan_i;
  logic              pend, pend_first;
  logic [3:0]        k;
  logic [7:0]        g;
  logic              imp1;
  logic [COST_W-1:0] bcur, ncost_r, bf_r, last_cost;
  logic [LEN_W-1:0]  len, fill_i, path_length;
  out_item_t         out_q;

  // frontier and multiplier
  fr_cmd_t           fr_cmd;
  fentry_t           fr_rdata, fr_best;
  fidx_t             fr_best_idx;
  logic [7:0]        mul_a;
  logic [8:0]        mul_b;
  logic [PROD_W-1:0] prod;

  gaps_frontier u_frontier (
    .clk      (clk),
    .cmd      (fr_cmd),
    .rdata    (fr_rdata),
    .best     (fr_best),
    .best_idx (fr_best_idx)
  );

  gaps_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // neighbor geometry
  logic [ROW_W-1:0]  r, nr, frow;
  logic [COL_W-1:0]  c, nc, fcol;
  logic [ROW_W+1:0]  nr_ext;
  logic [COL_W+1:0]  nc_ext;
  logic              in_bounds, diag;
  cell_t             n_cell, side1, side2;
  logic [ROW_W-1:0]  dr_abs;
  logic [COL_W-1:0]  dc_abs;
  logic [DIST_W-1:0] dmx, dmn;
  logic [COST_W:0]   nsum;
  logic [COST_W-1:0] ncost;
  logic [PRIO_W-1:0] prio;
  logic              cand, full, is_imp;

  assign r      = ROW_W'(cur / GRID_COLS);
  assign c      = COL_W'(cur % GRID_COLS);
  assign frow   = ROW_W'(f_cell / GRID_COLS);
  assign fcol   = COL_W'(f_cell % GRID_COLS);
  assign nr_ext = {2'b00, r} + {{ROW_W{1'b0}}, nb_row_code(k)} - (ROW_W+2)'(1);
  assign nc_ext = {2'b00, c} + {{COL_W{1'b0}}, nb_col_code(k)} - (COL_W+2)'(1);
  assign nr     = nr_ext[ROW_W-1:0];
  assign nc     = nc_ext[COL_W-1:0];
  assign in_bounds = (nr_ext < (ROW_W+2)'(GRID_ROWS)) && (nc_ext < (COL_W+2)'(GRID_COLS))
                     && (k != 4'd4);
  assign diag   = (nb_row_code(k) != 2'd1) && (nb_col_code(k) != 2'd1);
  assign n_cell = cell_of(nr, nc);
  assign side1  = cell_of(nr, c);
  assign side2  = cell_of(r, nc);
  assign is_imp = (grid_rdata == impassable_cost);

  assign dr_abs = (frow > nr) ? frow - nr : nr - frow;
  assign dc_abs = (fcol > nc) ? fcol - nc : nc - fcol;
  assign dmx    = (DIST_W'(dr_abs) > DIST_W'(dc_abs)) ? DIST_W'(dr_abs) : DIST_W'(dc_abs);
  assign dmn    = (DIST_W'(dr_abs) > DIST_W'(dc_abs)) ? DIST_W'(dc_abs) : DIST_W'(dr_abs);

  // saturating path cost of the candidate step
  assign nsum  = {1'b0, bcur} + (COST_W+1)'(prod);
  assign ncost = nsum[COST_W] ? COST_SAT : nsum[COST_W-1:0];
  assign cand  = !known[n_cell] || (ncost < best_rdata);
  assign full  = (count >= FCNT_W'(FRONTIER_DEPTH));
  assign prio  = {1'b0, ncost_r} + (PRIO_W'(dmx - dmn) << 8) + PRIO_W'(prod);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL: begin
        mul_a = g;
        mul_b = diag ? diag_weight : ORTHO_WEIGHT;
      end
      S_MUL2: begin
        mul_a = 8'(dmn);
        mul_b = diag_weight;
      end
      default: ;
    endcase
  end

  always_comb begin
    fr_cmd = '0;
    case (state)
      S_INIT: begin
        fr_cmd.wr_en = 1'b1;
        fr_cmd.waddr = '0;
        fr_cmd.wdata = '{prio: '0, seq: '0, loc: s_cell};
      end
      S_SCAN: begin
        fr_cmd.rd_en     = 1'b1;
        fr_cmd.raddr     = scan_i;
        fr_cmd.cmp_en    = pend;
        fr_cmd.cmp_first = pend_first;
      end
      S_SCEND: begin
        fr_cmd.cmp_en    = 1'b1;
        fr_cmd.cmp_first = pend_first;
      end
      S_MVRD: begin
        fr_cmd.rd_en = 1'b1;
        fr_cmd.raddr = FIDX_W'(count - FCNT_W'(1));
      end
      S_MVWR: begin
        fr_cmd.wr_en = 1'b1;
        fr_cmd.waddr = fr_best_idx;
        fr_cmd.wdata = fr_rdata;
      end
      S_PUSH: begin
        fr_cmd.wr_en = !full;
        fr_cmd.waddr = count[FIDX_W-1:0];
        fr_cmd.wdata = '{prio: prio, seq: seq, loc: n_cell};
      end
      default: ;
    endcase
  end

  // store addressing
  always_comb begin
    grid_we    = (state == S_IDLE) && in_valid && (in_data.req_type == REQ_LOAD) &&
                 ({1'b0, in_data.cell_index} < 9'(NCELLS));
    grid_raddr = n_cell;
    case (state)
      S_G1:    grid_raddr = side1;
      S_S1:    grid_raddr = side2;
      default: grid_raddr = n_cell;
    endcase
    best_we    = (state == S_INIT) || ((state == S_PUSH) && !full);
    best_waddr = (state == S_INIT) ? s_cell : n_cell;
    best_wdata = (state == S_INIT) ? '0 : ncost_r;
    case (state)
      S_MVWR:  best_raddr = cur;
      S_TRBF:  best_raddr = f_cell;
      default: best_raddr = n_cell;
    endcase
    par_we     = (state == S_PUSH) && !full;
    par_raddr  = tcur;
    path_we    = (state == S_FILL);
    path_waddr = CELL_W'(fill_i - LEN_W'(1));
    path_raddr = in_data.path_index;
  end

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[in_data.cell_index] <= in_data.cell_cost;
    end
    grid_rdata <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[best_waddr] <= best_wdata;
    end
    best_rdata <= best_mem[best_raddr];
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[n_cell] <= cur;
    end
    par_rdata <= par_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_waddr] <= tcur;
    end
    path_rdata <= path_mem[path_raddr];
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign out_data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      path_length <= '0;
      last_cost   <= '0;
      count       <= '0;
      known       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            s_cell           <= in_data.start_cell;
            f_cell           <= in_data.finish_cell;
            out_q.total_cost <= last_cost;
            out_q.path_len   <= path_length;
            out_q.path_cell  <= '0;
            case (in_data.req_type)
              REQ_SEARCH: begin
                known <= '0;
                count <= '0;
                seq   <= '0;
                if (({1'b0, in_data.start_cell} >= 9'(NCELLS)) ||
                    ({1'b0, in_data.finish_cell} >= 9'(NCELLS))) begin
                  out_q.status <= ST_NO_PATH;
                  state        <= S_DONE;
                end else begin
                  out_q.status <= ST_OK;
                  state        <= S_INIT;
                end
              end
              REQ_READ: begin
                if ({1'b0, in_data.path_index} < path_length) begin
                  out_q.status <= ST_OK;
                  state        <= S_RDW;
                end else begin
                  out_q.status <= ST_NO_PATH;
                  state        <= S_DONE;
                end
              end
              default: begin
                out_q.status <= ST_OK;
                state        <= S_DONE;
              end
            endcase
          end
        end
        S_RDW: begin
          out_q.path_cell <= path_rdata;
          state           <= S_DONE;
        end
        S_INIT: begin
          known[s_cell] <= 1'b1;
          count         <= FCNT_W'(1);
          seq           <= SEQ_W'(1);
          state         <= S_POP;
        end
        S_POP: begin
          scan_i     <= '0;
          pend       <= 1'b0;
          pend_first <= 1'b0;
          state      <= (count == '0) ? S_TRBF : S_SCAN;
        end
        S_SCAN: begin
          pend       <= 1'b1;
          pend_first <= (scan_i == '0);
          if ({1'b0, scan_i} == count - FCNT_W'(1)) begin
            state <= S_SCEND;
          end else begin
            scan_i <= scan_i + FIDX_W'(1);
          end
        end
        S_SCEND: state <= S_MVRD;
        S_MVRD: begin
          cur   <= fr_best.loc;
          state <= S_MVWR;
        end
        S_MVWR: begin
          count <= count - FCNT_W'(1);
          k     <= '0;
          state <= (cur == f_cell) ? S_TRBF : S_BC;
        end
        S_BC: begin
          bcur  <= best_rdata;
          state <= S_NB;
        end
        S_NB: begin
          if (k == 4'd9) begin
            state <= S_POP;
          end else if (!in_bounds) begin
            k <= k + 4'd1;
          end else begin
            state <= S_G1;
          end
        end
        S_G1: begin
          g <= grid_rdata;
          if (is_imp) begin
            k     <= k + 4'd1;
            state <= S_NB;
          end else begin
            state <= diag ? S_S1 : S_MUL;
          end
        end
        S_S1: begin
          imp1  <= is_imp;
          state <= S_S2;
        end
        S_S2: begin
          // diagonal blocked when both side cells are impassable
          if (imp1 && is_imp) begin
            k     <= k + 4'd1;
            state <= S_NB;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_MUL2;
        S_MUL2: begin
          ncost_r <= ncost;
          if (cand) begin
            state <= S_PUSH;
          end else begin
            k     <= k + 4'd1;
            state <= S_NB;
          end
        end
        S_PUSH: begin
          if (full) begin
            out_q.status <= ST_OVERFLOW;
            state        <= S_DONE;
          end else begin
            count         <= count + FCNT_W'(1);
            seq           <= seq + SEQ_W'(1);
            known[n_cell] <= 1'b1;
            k             <= k + 4'd1;
            state         <= S_NB;
          end
        end
        S_TRBF: begin
          tcur <= f_cell;
          len  <= LEN_W'(1);
          if (!known[f_cell] || (f_cell == s_cell)) begin
            out_q.status <= ST_NO_PATH;
            state        <= S_DONE;
          end else begin
            state <= S_TRBFL;
          end
        end
        S_TRBFL: begin
          bf_r  <= best_rdata;
          state <= S_TRCHK;
        end
        S_TRCHK: begin
          if (tcur == s_cell) begin
            fill_i <= len;
            tcur   <= f_cell;
            state  <= S_FILL;
          end else if (!known[tcur]) begin
            out_q.status <= ST_NO_PATH;
            state        <= S_DONE;
          end else begin
            state <= S_TRDAT;
          end
        end
        S_TRDAT: begin
          tcur <= par_rdata;
          // a chain longer than the grid is broken
          if (len >= LEN_W'(NCELLS)) begin
            out_q.status <= ST_NO_PATH;
            state        <= S_DONE;
          end else begin
            len   <= len + LEN_W'(1);
            state <= S_TRCHK;
          end
        end
        S_FILL: begin
          if (fill_i > LEN_W'(1)) begin
            state <= S_FILLD;
          end else begin
            path_length <= len;
            last_cost   <= bf_r;
            out_q       <= '{status: ST_FOUND, total_cost: bf_r, path_len: len,
                             path_cell: '0};
            state       <= S_DONE;
          end
        end
        S_FILLD: begin
          tcur   <= par_rdata;
          fill_i <= fill_i - LEN_W'(1);
          state  <= S_FILL;
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/grid_astar_path_search_top.sv =====
// top level of the grid path search block with its register port
`default_nettype none
// A* search over a 16 x 16 grid of 8-bit cell costs, 8-connected moves.
// Input channel in_valid/in_ready/in_data carries one request per item:
// load a cell cost, run a search from start to finish, or read one path cell.
// Output channel out_valid/out_ready/out_data returns exactly one result item
// per request, in request order.
// A load result is valid the cycle after the item is taken; a read result
// goes through the path store read and S_RDW first. Each search pop scans
// the whole frontier through a single read port and moves the last entry
// into the freed slot, then takes each neighbor in turn: off-grid ones are
// skipped, impassable ones after the grid read, diagonals also read both
// side cells, the rest pass the multiplier. Then the path is traced and stored.
// One item is in flight at a time: in_ready is high only when the block is
// idle and no result is waiting.
// When the receiver stalls, the result holds on out_data and no new item is
// taken until it is accepted.
// Reset clears control state, path length, last cost and the registers to
// impassable_cost 255, diag_weight 362. Grid cells must be loaded before a
// search examines them. Registers sit at byte addresses 0 and 4 of the APB port.
module grid_astar_path_search_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gaps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gaps_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import gaps_pkg::*;

  typedef enum logic {
    REG_IMPASSABLE = 1'b0,
    REG_DIAG       = 1'b1
  } reg_idx_t;

  logic [7:0] impassable_cost;
  logic [8:0] diag_weight;
  reg_idx_t   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      impassable_cost <= 8'd255;
      diag_weight     <= 9'd362;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_IMPASSABLE: impassable_cost <= pwdata[7:0];
        REG_DIAG:       diag_weight     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMPASSABLE: prdata = {24'd0, impassable_cost};
      REG_DIAG:       prdata = {23'd0, diag_weight};
      default:        prdata = '0;
    endcase
  end

  gaps_core u_core (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .impassable_cost (impassable_cost),
    .diag_weight     (diag_weight)
  );

endmodule
`default_nettype wire

// ===== rtl/gaps_checker.sv =====
// port-level checks for the grid path search block and their binding
`default_nettype none
`include "grid_astar_path_search_top_macros.svh"
module gaps_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gaps_pkg::out_item_t out_data
);
  import gaps_pkg::*;

  // a waiting result stays until taken
  `GAPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // one item in flight: taking an item drops ready
  `GAPS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // never ready for a new item while a result waits
  `GAPS_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)
  // no result right after reset
  `GAPS_ASSERT_ALWAYS(a_reset_quiet, rst, !out_valid)

endmodule

bind grid_astar_path_search_top gaps_checker u_gaps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
